// ===== rtl/mpa_pkg.sv =====
`timescale 1ns / 1ps

package mpa_pkg;

    localparam int MAX_TASKS  = 8;
    localparam int TICK_WIDTH = 16;
    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int PRIO_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_PRIORITY = CFG_IDX_W'(1);

    localparam logic [PRIO_W-1:0] HIGHEST_PRIORITY_RST = PRIO_W'(7);

    typedef enum logic {
        POLICY_RATE     = 1'b0,
        POLICY_DEADLINE = 1'b1
    } t_policy;

    typedef struct packed {
        t_policy             policy;
        logic [PRIO_W-1:0]   highest;
    } t_cfg;

endpackage

// ===== rtl/mpa_key_ram.sv =====
`timescale 1ns / 1ps

module mpa_key_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mpa_ctrl.sv =====
`timescale 1ns / 1ps

module mpa_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mpa_pkg::t_cfg                       i_cfg,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mpa_pkg::TICK_WIDTH-1:0]      i_period_ticks,
    input  logic [mpa_pkg::TICK_WIDTH-1:0]      i_deadline_ticks,
    input  logic                                i_last_task,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mpa_pkg::SLOT_W-1:0]          o_task_slot,
    output logic [mpa_pkg::PRIO_W-1:0]          o_assigned_priority,
    output logic                                o_last_result
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                            r_state, n_state;
    logic [mpa_pkg::CNT_W-1:0]         r_count, n_count;
    logic [mpa_pkg::CNT_W-1:0]         r_total, n_total;
    logic [mpa_pkg::CNT_W-1:0]         r_k, n_k;
    logic [mpa_pkg::MAX_TASKS-1:0]     r_flags, n_flags;
    logic [mpa_pkg::PRIO_W-1:0]        r_prio, n_prio;
    logic [mpa_pkg::SLOT_W-1:0]        r_rd_addr, n_rd_addr;
    logic                              r_rd_busy, n_rd_busy;
    logic                              r_cmp_vld, n_cmp_vld;
    logic [mpa_pkg::SLOT_W-1:0]        r_cmp_idx, n_cmp_idx;
    logic                              r_best_vld, n_best_vld;
    logic [mpa_pkg::SLOT_W-1:0]        r_best_idx, n_best_idx;
    logic [mpa_pkg::TICK_WIDTH-1:0]    r_best_key, n_best_key;
    logic                              r_out_valid, n_out_valid;
    logic [mpa_pkg::SLOT_W-1:0]        r_out_slot, n_out_slot;
    logic [mpa_pkg::PRIO_W-1:0]        r_out_prio, n_out_prio;
    logic                              r_out_last, n_out_last;

    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_we;
    logic [mpa_pkg::TICK_WIDTH-1:0]    w_wkey;
    logic                              w_re;
    logic [mpa_pkg::TICK_WIDTH-1:0]    w_rkey;

    mpa_key_ram #(
        .DEPTH (mpa_pkg::MAX_TASKS),
        .WIDTH (mpa_pkg::TICK_WIDTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[mpa_pkg::SLOT_W-1:0]),
        .i_wdata (w_wkey),
        .i_re    (w_re),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rkey)
    );

    assign o_in_ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_we       = w_in_acc && (r_count < mpa_pkg::CNT_W'(mpa_pkg::MAX_TASKS));
    assign w_wkey     = (i_cfg.policy == mpa_pkg::POLICY_DEADLINE) ? i_deadline_ticks
                                                                   : i_period_ticks;
    assign w_re       = (r_state == S_SCAN) && r_rd_busy;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_k         = r_k;
        n_flags     = r_flags;
        n_prio      = r_prio;
        n_rd_addr   = r_rd_addr;
        n_rd_busy   = r_rd_busy;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_best_vld  = r_best_vld;
        n_best_idx  = r_best_idx;
        n_best_key  = r_best_key;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_slot  = r_out_slot;
        n_out_prio  = r_out_prio;
        n_out_last  = r_out_last;

        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_we) begin
                        n_count = r_count + mpa_pkg::CNT_W'(1);
                    end
                    if (i_last_task) begin
                        n_total    = n_count;
                        n_k        = '0;
                        n_prio     = i_cfg.highest;
                        n_rd_addr  = '0;
                        n_rd_busy  = 1'b1;
                        n_best_vld = 1'b0;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_busy) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_addr;
                    if (mpa_pkg::CNT_W'(r_rd_addr) + mpa_pkg::CNT_W'(1) == r_total) begin
                        n_rd_busy = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + mpa_pkg::SLOT_W'(1);
                    end
                end
                if (r_cmp_vld) begin
                    if (!r_flags[r_cmp_idx] && (!r_best_vld || w_rkey < r_best_key)) begin
                        n_best_vld = 1'b1;
                        n_best_idx = r_cmp_idx;
                        n_best_key = w_rkey;
                    end
                    if (mpa_pkg::CNT_W'(r_cmp_idx) + mpa_pkg::CNT_W'(1) == r_total) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_slot           = r_best_idx;
                    n_out_prio           = r_prio;
                    n_out_last           = (r_k + mpa_pkg::CNT_W'(1) == r_total);
                    n_flags[r_best_idx]  = 1'b1;
                    if (r_prio != '0) begin
                        n_prio = r_prio - mpa_pkg::PRIO_W'(1);
                    end
                    if (n_out_last) begin
                        n_count = '0;
                        n_flags = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k        = r_k + mpa_pkg::CNT_W'(1);
                        n_rd_addr  = '0;
                        n_rd_busy  = 1'b1;
                        n_best_vld = 1'b0;
                        n_state    = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_flags     <= '0;
            r_prio      <= '0;
            r_rd_busy   <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_prio      <= n_prio;
            r_rd_busy   <= n_rd_busy;
            r_cmp_vld   <= n_cmp_vld;
            r_best_vld  <= n_best_vld;
            r_out_valid <= n_out_valid;
        end
        r_total    <= n_total;
        r_k        <= n_k;
        r_rd_addr  <= n_rd_addr;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_out_slot <= n_out_slot;
        r_out_prio <= n_out_prio;
        r_out_last <= n_out_last;
    end

    assign o_out_valid         = r_out_valid;
    assign o_task_slot         = r_out_slot;
    assign o_assigned_priority = r_out_prio;
    assign o_last_result       = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mpa_pkg::CNT_W'(mpa_pkg::MAX_TASKS))
        else $error("load count beyond capacity");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (mpa_pkg::CNT_W'(r_cmp_idx) < r_total))
        else $error("compare index beyond loaded tasks");

    a_pick_unassigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_best_vld && !r_flags[r_best_idx]))
        else $error("pick of an assigned or missing task");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && n_out_last) |=> (r_count == '0 && r_flags == '0))
        else $error("run end did not clear load state");

endmodule

// ===== rtl/monotonic_priority_assigner.sv =====
`timescale 1ns / 1ps
// Monotonic priority assigner.
// Input channel (i_in_valid / o_in_ready): one task descriptor per transaction.
// The key stored is the period or the deadline, chosen by policy_mode at the
// time of the transaction. Up to MAX_TASKS are kept; extra ones are dropped.
// A transaction with i_last_task set closes the batch and starts assignment.
// Output channel (o_out_valid / i_out_ready): one transaction per loaded task,
// in pick order (smallest key first, lowest slot on a tie), with priorities
// counting down from highest_priority and holding at zero.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 policy_mode,
// index 1 highest_priority; other indexes are dropped. Always ready.
// With N tasks loaded, each pick is made of N reads of the key memory through
// its single read port, one compare pipeline stage and one emit step.
// Inputs are refused for the whole run.
// A stalled receiver holds the output register and the run pauses at emit.
// Reset (synchronous, active low) clears the batch, the run and the output;
// policy_mode returns to 0 and highest_priority to 7.

module monotonic_priority_assigner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mpa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mpa_pkg::TICK_WIDTH-1:0]      i_period_ticks,
    input  logic [mpa_pkg::TICK_WIDTH-1:0]      i_deadline_ticks,
    input  logic                                i_last_task,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mpa_pkg::SLOT_W-1:0]          o_task_slot,
    output logic [mpa_pkg::PRIO_W-1:0]          o_assigned_priority,
    output logic                                o_last_result
);

    mpa_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy  <= mpa_pkg::POLICY_RATE;
            r_cfg.highest <= mpa_pkg::HIGHEST_PRIORITY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mpa_pkg::CFG_POLICY_MODE: begin
                    r_cfg.policy <= mpa_pkg::t_policy'(i_cfg_data[0]);
                end
                mpa_pkg::CFG_HIGHEST_PRIORITY: begin
                    r_cfg.highest <= i_cfg_data[mpa_pkg::PRIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mpa_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_period_ticks      (i_period_ticks),
        .i_deadline_ticks    (i_deadline_ticks),
        .i_last_task         (i_last_task),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_task_slot         (o_task_slot),
        .o_assigned_priority (o_assigned_priority),
        .o_last_result       (o_last_result)
    );

endmodule

// ===== bench/monotonic_priority_assigner_tb.sv =====
`timescale 1ns / 1ps

module monotonic_priority_assigner_tb;

    localparam int RAND_ITEMS    = 388;
    localparam int CALM_ITEMS    = 40;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [mpa_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE =
        mpa_pkg::CFG_HIGHEST_PRIORITY + 1'b1;
    localparam logic [mpa_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP   = '1;

    typedef struct packed {
        logic [mpa_pkg::SLOT_W-1:0] slot;
        logic [mpa_pkg::PRIO_W-1:0] prio;
        logic                       fin;
    } t_pick;

    typedef enum logic {
        ROW_TASK,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [mpa_pkg::CFG_IDX_W-1:0]  idx;
        logic [mpa_pkg::CFG_DATA_W-1:0] data;
        logic [mpa_pkg::TICK_WIDTH-1:0] per;
        logic [mpa_pkg::TICK_WIDTH-1:0] dl;
        logic                           fin;
        logic                           pinned;
        t_pick                          pick;
    } t_row;

    logic                           i_clk            = 1'b0;
    logic                           i_rst_n          = 1'b0;
    logic                           i_cfg_valid      = 1'b0;
    logic                           o_cfg_ready;
    logic [mpa_pkg::CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [mpa_pkg::CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                           i_in_valid       = 1'b0;
    logic                           o_in_ready;
    logic [mpa_pkg::TICK_WIDTH-1:0] i_period_ticks   = '0;
    logic [mpa_pkg::TICK_WIDTH-1:0] i_deadline_ticks = '0;
    logic                           i_last_task      = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready      = 1'b0;
    logic [mpa_pkg::SLOT_W-1:0]     o_task_slot;
    logic [mpa_pkg::PRIO_W-1:0]     o_assigned_priority;
    logic                           o_last_result;

    // typed expectation carried along with the transaction it belongs to
    logic                  pin_on  = 1'b0;
    t_pick                 pin_pick = '0;

    bit calm  = 1'b0;
    bit quiet = 1'b0;

    mpa_pkg::t_policy               cfg_policy = mpa_pkg::POLICY_RATE;
    logic [mpa_pkg::PRIO_W-1:0]     cfg_top    = mpa_pkg::HIGHEST_PRIORITY_RST;
    logic [mpa_pkg::TICK_WIDTH-1:0] key_mem [mpa_pkg::MAX_TASKS];
    int                             n_loaded   = 0;
    t_pick                          pending_picks [$];

    int n_errors  = 0;
    int n_sent    = 0;
    int n_results = 0;
    int n_batches = 0;
    int n_writes  = 0;
    int cycles    = 0;

    t_row directed_rows [30];

    monotonic_priority_assigner i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_period_ticks      (i_period_ticks),
        .i_deadline_ticks    (i_deadline_ticks),
        .i_last_task         (i_last_task),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_task_slot         (o_task_slot),
        .o_assigned_priority (o_assigned_priority),
        .o_last_result       (o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_row task_row(input logic [mpa_pkg::TICK_WIDTH-1:0] per,
                                      input logic [mpa_pkg::TICK_WIDTH-1:0] dl,
                                      input logic fin);
        return '{ROW_TASK, '0, '0, per, dl, fin, 1'b0, '0};
    endfunction

    function automatic t_row pin_row(input logic [mpa_pkg::TICK_WIDTH-1:0] per,
                                     input logic [mpa_pkg::TICK_WIDTH-1:0] dl,
                                     input logic [mpa_pkg::PRIO_W-1:0] prio);
        return '{ROW_TASK, '0, '0, per, dl, 1'b1, 1'b1, '{'0, prio, 1'b1}};
    endfunction

    function automatic t_row reg_row(input logic [mpa_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [mpa_pkg::CFG_DATA_W-1:0] data);
        return '{ROW_REG, idx, data, '0, '0, 1'b0, 1'b0, '0};
    endfunction

    function automatic void take_descriptor(input logic [mpa_pkg::TICK_WIDTH-1:0] per,
                                            input logic [mpa_pkg::TICK_WIDTH-1:0] dl,
                                            input logic fin);
        logic [mpa_pkg::MAX_TASKS-1:0] taken;
        logic [mpa_pkg::PRIO_W-1:0]    prio;
        int                            best;
        if (n_loaded < mpa_pkg::MAX_TASKS) begin
            key_mem[n_loaded] = (cfg_policy == mpa_pkg::POLICY_DEADLINE) ? dl : per;
            n_loaded++;
        end
        if (!fin) begin
            return;
        end
        taken = '0;
        prio  = cfg_top;
        for (int k = 0; k < n_loaded; k++) begin
            best = -1;
            for (int i = 0; i < n_loaded; i++) begin
                if (!taken[i] && (best < 0 || key_mem[i] < key_mem[best])) begin
                    best = i;
                end
            end
            taken[best] = 1'b1;
            pending_picks.push_back('{mpa_pkg::SLOT_W'(best), prio, k == n_loaded - 1});
            if (prio != 0) begin
                prio--;
            end
        end
        n_loaded = 0;
    endfunction

    function automatic logic [mpa_pkg::TICK_WIDTH-1:0] make_tick(input int style);
        int s;
        s = (style > 3) ? $urandom_range(0, 3) : style;
        case (s)
            0: return mpa_pkg::TICK_WIDTH'($urandom);
            1: return mpa_pkg::TICK_WIDTH'($urandom_range(0, 7));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return mpa_pkg::TICK_WIDTH'(1);
                    default: return {{(mpa_pkg::TICK_WIDTH-1){1'b1}}, 1'b0};
                endcase
            end
            default: return ~mpa_pkg::TICK_WIDTH'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic int sender_gap();
        if (calm || quiet || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        return $urandom_range(1, 9);
    endfunction

    function automatic logic [mpa_pkg::PRIO_W-1:0] pick_top();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return mpa_pkg::PRIO_W'(1);
            default: return mpa_pkg::PRIO_W'($urandom);
        endcase
    endfunction

    task automatic send_task(input logic [mpa_pkg::TICK_WIDTH-1:0] per,
                             input logic [mpa_pkg::TICK_WIDTH-1:0] dl,
                             input logic fin,
                             input logic pinned,
                             input t_pick pick);
        int gap;
        i_in_valid       <= 1'b1;
        i_period_ticks   <= per;
        i_deadline_ticks <= dl;
        i_last_task      <= fin;
        pin_on           <= pinned;
        pin_pick         <= pick;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [mpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mpa_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_writes++;
        @(posedge i_clk);
    endtask

    // drop valid, drain every pending result, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic shuffle_regs();
        settle();
        if ($urandom_range(0, 1) != 0) begin
            write_reg(mpa_pkg::CFG_POLICY_MODE, mpa_pkg::CFG_DATA_W'($urandom));
        end
        if ($urandom_range(0, 1) != 0) begin
            write_reg(mpa_pkg::CFG_HIGHEST_PRIORITY, pick_top());
        end
        if ($urandom_range(0, 5) == 0) begin
            write_reg(mpa_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP)),
                      mpa_pkg::CFG_DATA_W'($urandom));
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_pick want;
        int    base;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_picks.size() == 0) begin
                    $error("unexpected result: task_slot %0d assigned_priority %0d",
                           o_task_slot, o_assigned_priority);
                    n_errors++;
                end else begin
                    want = pending_picks.pop_front();
                    if (o_task_slot !== want.slot) begin
                        $error("task_slot: expected %0d, actual %0d", want.slot, o_task_slot);
                        n_errors++;
                    end
                    if (o_assigned_priority !== want.prio) begin
                        $error("assigned_priority: expected %0d, actual %0d",
                               want.prio, o_assigned_priority);
                        n_errors++;
                    end
                    if (o_last_result !== want.fin) begin
                        $error("last_result: expected %0d, actual %0d", want.fin, o_last_result);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                base = pending_picks.size();
                take_descriptor(i_period_ticks, i_deadline_ticks, i_last_task);
                if (pin_on && pending_picks.size() > base) begin
                    pending_picks[base] = pin_pick;
                end
                if (i_last_task) begin
                    n_batches++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mpa_pkg::CFG_POLICY_MODE:
                        cfg_policy = mpa_pkg::t_policy'(i_cfg_data[0]);
                    mpa_pkg::CFG_HIGHEST_PRIORITY: cfg_top = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial begin : out_stall
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int                             stored;
        int                             blen;
        int                             style;
        int                             mid;
        logic [mpa_pkg::TICK_WIDTH-1:0] per;
        logic [mpa_pkg::TICK_WIDTH-1:0] dl;

        directed_rows = '{
            pin_row(16'hFFFF, 16'h0000, 8'd7),
            task_row(16'hFFFF, 16'h1234, 1'b0),
            task_row(16'h0005, 16'hFFFF, 1'b0),
            task_row(16'h0005, 16'h0000, 1'b0),
            task_row(16'h0000, 16'hABCD, 1'b0),
            task_row(16'hFFFF, 16'h0001, 1'b0),
            task_row(16'h0064, 16'h5555, 1'b0),
            task_row(16'h0000, 16'hAAAA, 1'b0),
            task_row(16'h0007, 16'hFFFE, 1'b0),
            task_row(16'h1111, 16'h2222, 1'b0),
            task_row(16'h0003, 16'h0004, 1'b1),
            reg_row(mpa_pkg::CFG_HIGHEST_PRIORITY, 8'h00),
            task_row(16'h0009, 16'h0000, 1'b0),
            task_row(16'h0002, 16'h0000, 1'b0),
            task_row(16'hFFFF, 16'h0000, 1'b1),
            reg_row(mpa_pkg::CFG_POLICY_MODE, mpa_pkg::CFG_DATA_W'(mpa_pkg::POLICY_DEADLINE)),
            reg_row(mpa_pkg::CFG_HIGHEST_PRIORITY, 8'hFF),
            pin_row(16'h0000, 16'hFFFF, 8'hFF),
            task_row(16'h8000, 16'h0010, 1'b0),
            task_row(16'h7FFF, 16'h0010, 1'b0),
            reg_row(mpa_pkg::CFG_POLICY_MODE, mpa_pkg::CFG_DATA_W'(mpa_pkg::POLICY_RATE)),
            task_row(16'h0001, 16'hFFFF, 1'b0),
            task_row(16'h0000, 16'h0000, 1'b1),
            reg_row(CFG_IDX_SPARE, 8'hAA),
            reg_row(CFG_IDX_TOP, 8'h55),
            pin_row(16'hFFFF, 16'hFFFF, 8'hFF),
            reg_row(mpa_pkg::CFG_HIGHEST_PRIORITY, 8'h01),
            task_row(16'h0300, 16'h0000, 1'b0),
            task_row(16'h0200, 16'h0000, 1'b0),
            task_row(16'h0100, 16'h0000, 1'b1)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG) begin
                settle();
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                send_task(directed_rows[r].per, directed_rows[r].dl, directed_rows[r].fin,
                          directed_rows[r].pinned, directed_rows[r].pick);
            end
        end

        stored = 0;
        while (stored < RAND_ITEMS) begin
            calm = (stored >= RAND_ITEMS - CALM_ITEMS);
            if (!calm && $urandom_range(0, 2) == 0) begin
                shuffle_regs();
            end
            quiet = !calm && ($urandom_range(0, 3) == 0);
            blen  = ($urandom_range(0, 9) == 0)
                    ? $urandom_range(mpa_pkg::MAX_TASKS + 1, mpa_pkg::MAX_TASKS + 3)
                    : $urandom_range(1, mpa_pkg::MAX_TASKS);
            style = $urandom_range(0, 4);
            mid   = (!calm && blen > 2 && $urandom_range(0, 5) == 0)
                    ? $urandom_range(1, blen - 1) : 0;
            for (int j = 0; j < blen; j++) begin
                if (mid != 0 && j == mid) begin
                    settle();
                    write_reg(mpa_pkg::CFG_POLICY_MODE, mpa_pkg::CFG_DATA_W'($urandom));
                end
                per = make_tick(style);
                dl  = make_tick(style);
                send_task(per, dl, j == blen - 1, 1'b0, '0);
                if (j < mpa_pkg::MAX_TASKS) begin
                    stored++;
                end
            end
        end

        calm = 1'b1;
        settle();

        $display("covered %0d task transactions in %0d batches with %0d register writes",
                 n_sent, n_batches, n_writes);
        $display("checked %0d assignment results, %0d mismatches", n_results, n_errors);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
